// ===== rtl/tcqg_pkg.sv =====
// Shared types, widths and constants of the tile cell quad generator.
package tcqg_pkg;

   localparam int TILE_IDS_DEF = 4096;

   // field and datapath widths
   localparam int IDX_W    = 13;
   localparam int ROW_W    = 13;
   localparam int COL_W    = 8;
   localparam int UN_W     = 26;
   localparam int VN_W     = 31;
   localparam int POS_W    = 21;
   localparam int TEX_W    = 17;
   localparam int CLS_W    = 2;
   localparam int CORNER_W = 3;
   localparam int PADDR_W  = 5;
   localparam int DATA_W   = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [POS_W-1:0]    POS_MAX     = '1;
   localparam logic [TEX_W-1:0]    TEX_MAX     = '1;
   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd5;

   // per corner: bit k selects the far edge (x1/u1, y1/v1) for vertex k
   localparam logic [7:0] SEL_X = 8'b0011_0010;
   localparam logic [7:0] SEL_Y = 8'b0010_1100;

   localparam logic [CLS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLS_W-1:0] CLASS_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      REG_FIRST_ID    = 3'd0,
      REG_TILE_TOTAL  = 3'd1,
      REG_ATLAS_COLS  = 3'd2,
      REG_TILE_SIZE   = 3'd3,
      REG_IMG_EXTENT  = 3'd4,
      REG_MARGIN_GAP  = 3'd5,
      REG_CELL_SIZE   = 3'd6,
      REG_TINT        = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] first_id;
      logic [12:0] tile_total;
      logic [7:0]  atlas_columns;
      logic [31:0] tile_size;
      logic [31:0] img_extent;
      logic [31:0] margin_gap;
      logic [31:0] cell_size;
      logic [31:0] tint;
   } cfg_type;

   // one classified cell on its way from front to back
   typedef struct packed {
      logic [UN_W-1:0]  un;
      logic [VN_W-1:0]  vn;
      logic [POS_W-1:0] x0;
      logic [POS_W-1:0] x1;
      logic [POS_W-1:0] y0;
      logic [POS_W-1:0] y1;
      logic [CLS_W-1:0] wc;
   } cell_job_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic [26:0] p);
      return (p > 27'(POS_MAX)) ? POS_MAX : p[POS_W-1:0];
   endfunction

endpackage

// ===== rtl/tcqg_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tcqg_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tcqg_front.sv =====
// Front end: accepts items, updates the walk-class table, range-checks ids and
// splits the tile index into atlas column and row.
module tcqg_front import tcqg_pkg::*; #(
   parameter int TILE_IDS = TILE_IDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_mode,
   input  logic [9:0]   req_cell_x,
   input  logic [9:0]   req_cell_y,
   input  logic [15:0]  req_tile_gid,
   input  logic [11:0]  req_attr_tile,
   input  logic [1:0]   req_attr_class,
   input  cfg_type      cfg,
   output logic         job_valid,
   input  logic         job_ready,
   output cell_job_type job
);

   localparam int AW        = $clog2(TILE_IDS);
   localparam int DIV_STEPS = 4;
   localparam int NUM_W     = 16;
   localparam int STEP_W    = 2;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W / DIV_STEPS - 1);

   typedef enum logic [3:0] {
      F_CLEAR = 4'b0001,
      F_IDLE  = 4'b0010,
      F_RUN   = 4'b0100,
      F_DONE  = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COL_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [9:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic              in_tab_ff, in_tab_in;

   logic              accept, in_range, draw_go, tab_write, clearing;
   logic [16:0]       id_end;
   logic [15:0]       id_off;
   logic [IDX_W-1:0]  idx;
   logic [COL_W-1:0]  cols;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CLS_W-1:0]  ram_wdata, ram_rdata;
   logic [COL_W:0]    div_t;
   logic [COL_W-1:0]  div_r;
   logic [NUM_W-1:0]  div_q;
   logic [16:0]       u_pitch, v_pitch;
   logic [24:0]       u_prod;
   logic [29:0]       v_prod;
   logic [25:0]       x0_raw, y0_raw;

   assign clearing  = (state_ff == F_CLEAR);
   assign req_ready = (state_ff == F_IDLE) || ((state_ff == F_DONE) && job_ready);
   assign accept    = req_valid && req_ready;

   // id range check and tile index
   assign id_end   = {1'b0, cfg.first_id} + {4'd0, cfg.tile_total};
   assign in_range = (req_tile_gid >= cfg.first_id) && ({1'b0, req_tile_gid} < id_end);
   assign id_off   = req_tile_gid - cfg.first_id;
   assign idx      = id_off[IDX_W-1:0];
   assign draw_go  = accept && !req_mode && in_range;
   assign tab_write = accept && req_mode && (32'(req_attr_tile) < TILE_IDS);

   // walk-class table: cleared by a sweep after reset
   assign ram_we    = clearing || tab_write;
   assign ram_waddr = clearing ? clr_addr_ff : AW'(req_attr_tile);
   assign ram_wdata = (clearing || (req_attr_class == CLASS_UNUSED)) ? CLASS_NONE
                                                                     : req_attr_class;
   assign ram_raddr = AW'(idx);

   tcqg_ram #(.WIDTH(CLS_W), .DEPTH(TILE_IDS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (draw_go),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign cols = (cfg.atlas_columns == '0) ? COL_W'(1) : cfg.atlas_columns;

   // restoring divide, four quotient bits per cycle
   always_comb begin
      div_r = rem_ff;
      div_q = num_ff;
      div_t = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         div_t = {div_r, div_q[NUM_W-1]};
         div_q = {div_q[NUM_W-2:0], 1'b0};
         if (div_t >= {1'b0, cols}) begin
            div_t    = div_t - {1'b0, cols};
            div_q[0] = 1'b1;
         end
         div_r = div_t[COL_W-1:0];
      end
   end

   // control
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      in_tab_in   = in_tab_ff;
      unique case (state_ff)
         F_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TILE_IDS - 1)) begin
               state_in = F_IDLE;
            end
         end
         F_IDLE, F_DONE: begin
            if ((state_ff == F_DONE) && job_ready) begin
               state_in = F_IDLE;
            end
            if (draw_go) begin
               state_in  = F_RUN;
               step_in   = '0;
               rem_in    = '0;
               num_in    = {3'd0, idx};
               cx_in     = req_cell_x;
               cy_in     = req_cell_y;
               in_tab_in = (32'(idx) < TILE_IDS);
            end
         end
         F_RUN: begin
            rem_in  = div_r;
            num_in  = div_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = F_DONE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      in_tab_ff <= in_tab_in;
   end

   // texel offsets and screen positions of the finished cell
   assign u_pitch = {1'b0, cfg.tile_size[15:0]}  + {1'b0, cfg.margin_gap[31:16]};
   assign v_pitch = {1'b0, cfg.tile_size[31:16]} + {1'b0, cfg.margin_gap[31:16]};
   assign u_prod  = rem_ff * u_pitch;
   assign v_prod  = num_ff[ROW_W-1:0] * v_pitch;
   assign x0_raw  = cx_ff * cfg.cell_size[15:0];
   assign y0_raw  = cy_ff * cfg.cell_size[31:16];

   assign job_valid = (state_ff == F_DONE);
   assign job.un = {1'b0, u_prod} + {10'd0, cfg.margin_gap[15:0]};
   assign job.vn = {1'b0, v_prod} + {15'd0, cfg.margin_gap[15:0]};
   assign job.x0 = sat_pos({1'b0, x0_raw});
   assign job.x1 = sat_pos({1'b0, x0_raw} + {11'd0, cfg.cell_size[15:0]});
   assign job.y0 = sat_pos({1'b0, y0_raw});
   assign job.y1 = sat_pos({1'b0, y0_raw} + {11'd0, cfg.cell_size[31:16]});
   assign job.wc = in_tab_ff ? ram_rdata : CLASS_NONE;

endmodule

// ===== rtl/tcqg_queue.sv =====
// Short job queue between the front and back ends.
module tcqg_queue import tcqg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  cell_job_type in_job,
   output logic         out_valid,
   input  logic         out_ready,
   output cell_job_type out_job
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cell_job_type  slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != (PW + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// ===== rtl/tcqg_back.sv =====
// Back end: normalizes the four texture edges with iterative dividers and
// streams the six vertices of each cell.
module tcqg_back import tcqg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  cell_job_type        job,
   input  cfg_type             cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_pos_x,
   output logic [POS_W-1:0]    rsp_pos_y,
   output logic [TEX_W-1:0]    rsp_tex_u,
   output logic [TEX_W-1:0]    rsp_tex_v,
   output logic [31:0]         rsp_vert_color,
   output logic [CLS_W-1:0]    rsp_walk_class,
   output logic [CORNER_W-1:0] rsp_corner,
   output logic                rsp_last
);

   localparam int LANES     = 4;   // u0, u1, v0, v1
   localparam int Q_W       = 20;
   localparam int DIV_STEPS = 4;
   localparam int STEP_W    = 3;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W / DIV_STEPS - 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_HOLD = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [15:0]       lrem_ff [LANES];
   logic [15:0]       lrem_in [LANES];
   logic [Q_W-1:0]    lq_ff   [LANES];
   logic [Q_W-1:0]    lq_in   [LANES];
   logic [LANES-1:0]  lsat_ff, lsat_in;
   logic [POS_W-1:0]  cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic [CLS_W-1:0]  cwc_ff;

   logic              emit_valid_ff, emit_valid_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic [POS_W-1:0]  ex0_ff, ex1_ff, ey0_ff, ey1_ff;
   logic [TEX_W-1:0]  etex_ff [LANES];
   logic [CLS_W-1:0]  ewc_ff;

   logic [15:0]       wdiv   [LANES];
   logic [31:0]       lnum   [LANES];
   logic [32:0]       ldiv   [LANES];
   logic [16:0]       dt     [LANES];
   logic [TEX_W-1:0]  ltex   [LANES];
   logic [15:0]       iw, ih;
   logic              emit_free, load, xfer, rsp_take;

   assign iw = (cfg.img_extent[15:0]  == '0) ? 16'd1 : cfg.img_extent[15:0];
   assign ih = (cfg.img_extent[31:16] == '0) ? 16'd1 : cfg.img_extent[31:16];

   assign rsp_take  = rsp_valid && rsp_ready;
   assign emit_free = !emit_valid_ff || (rsp_take && (corner_ff == CORNER_LAST));
   assign job_ready = (state_ff == B_IDLE) || ((state_ff == B_HOLD) && emit_free);
   assign load      = job_valid && job_ready;
   assign xfer      = (state_ff == B_HOLD) && emit_free;

   // lane operands: pixel offset and image extent
   always_comb begin
      wdiv[0] = iw;
      wdiv[1] = iw;
      wdiv[2] = ih;
      wdiv[3] = ih;
      lnum[0] = {6'd0, job.un};
      lnum[1] = {6'd0, job.un} + {16'd0, cfg.tile_size[15:0]};
      lnum[2] = {1'b0, job.vn};
      lnum[3] = {1'b0, job.vn} + {16'd0, cfg.tile_size[31:16]};
      for (int l = 0; l < LANES; l++) begin
         // dividend is n * 65536 + W / 2
         ldiv[l] = {lnum[l][16:0], 16'd0} + {18'd0, wdiv[l][15:1]};
         ltex[l] = lsat_ff[l] ? TEX_MAX : lq_ff[l][TEX_W-1:0];
      end
   end

   // four dividers, four quotient bits each per cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      lsat_in  = lsat_ff;
      for (int l = 0; l < LANES; l++) begin
         lrem_in[l] = lrem_ff[l];
         lq_in[l]   = lq_ff[l];
         dt[l]      = '0;
      end
      unique case (state_ff)
         B_IDLE, B_HOLD: begin
            if (xfer) begin
               state_in = B_IDLE;
            end
            if (load) begin
               state_in = B_RUN;
               step_in  = '0;
               for (int l = 0; l < LANES; l++) begin
                  lsat_in[l] = (lnum[l] >= {15'd0, wdiv[l], 1'b0});
                  lrem_in[l] = {3'd0, ldiv[l][32:Q_W]};
                  lq_in[l]   = ldiv[l][Q_W-1:0];
               end
            end
         end
         B_RUN: begin
            for (int l = 0; l < LANES; l++) begin
               for (int k = 0; k < DIV_STEPS; k++) begin
                  dt[l]    = {lrem_in[l], lq_in[l][Q_W-1]};
                  lq_in[l] = {lq_in[l][Q_W-2:0], 1'b0};
                  if (dt[l] >= {1'b0, wdiv[l]}) begin
                     dt[l]       = dt[l] - {1'b0, wdiv[l]};
                     lq_in[l][0] = 1'b1;
                  end
                  lrem_in[l] = dt[l][15:0];
               end
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = B_HOLD;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // vertex sequencing
   always_comb begin
      emit_valid_in = emit_valid_ff;
      corner_in     = corner_ff;
      if (xfer) begin
         emit_valid_in = 1'b1;
         corner_in     = '0;
      end else if (rsp_take) begin
         if (corner_ff == CORNER_LAST) begin
            emit_valid_in = 1'b0;
         end else begin
            corner_in = corner_ff + CORNER_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         emit_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         emit_valid_ff <= emit_valid_in;
      end
      step_ff   <= step_in;
      lsat_ff   <= lsat_in;
      corner_ff <= corner_in;
      for (int l = 0; l < LANES; l++) begin
         lrem_ff[l] <= lrem_in[l];
         lq_ff[l]   <= lq_in[l];
      end
      if (load) begin
         cx0_ff <= job.x0;
         cx1_ff <= job.x1;
         cy0_ff <= job.y0;
         cy1_ff <= job.y1;
         cwc_ff <= job.wc;
      end
      if (xfer) begin
         ex0_ff <= cx0_ff;
         ex1_ff <= cx1_ff;
         ey0_ff <= cy0_ff;
         ey1_ff <= cy1_ff;
         ewc_ff <= cwc_ff;
         for (int l = 0; l < LANES; l++) begin
            etex_ff[l] <= ltex[l];
         end
      end
   end

   // corner select
   assign rsp_valid      = emit_valid_ff;
   assign rsp_pos_x      = SEL_X[corner_ff] ? ex1_ff : ex0_ff;
   assign rsp_pos_y      = SEL_Y[corner_ff] ? ey1_ff : ey0_ff;
   assign rsp_tex_u      = SEL_X[corner_ff] ? etex_ff[1] : etex_ff[0];
   assign rsp_tex_v      = SEL_Y[corner_ff] ? etex_ff[3] : etex_ff[2];
   assign rsp_vert_color = cfg.tint;
   assign rsp_walk_class = ewc_ff;
   assign rsp_corner     = corner_ff;
   assign rsp_last       = (corner_ff == CORNER_LAST);

endmodule

// ===== rtl/tile_cell_quad_generator_core.sv =====
// Top level of the tile cell quad generator: register file and datapath.
//
//  channel   direction  handshake            carries
//  req_*     in         req_valid/req_ready  map cell or walk-class table write
//  rsp_*     out        rsp_valid/rsp_ready  one vertex, six per drawn cell
//  csr       in/out     psel/penable/pready  eight 32-bit registers
//
// A drawn cell's sustained rate is set by the six-vertex output stream; the front
// divider and the texture dividers keep pace.
// Table writes and out-of-range ids give no vertex.
// After reset the walk-class table is swept with req_ready low.
// A stalled rsp side backs up through a two-entry queue into the front.
module tile_cell_quad_generator_core import tcqg_pkg::*; #(
   parameter int TILE_IDS = TILE_IDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [9:0]          req_cell_x,
   input  logic [9:0]          req_cell_y,
   input  logic [15:0]         req_tile_gid,
   input  logic [11:0]         req_attr_tile,
   input  logic [1:0]          req_attr_class,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_pos_x,
   output logic [POS_W-1:0]    rsp_pos_y,
   output logic [TEX_W-1:0]    rsp_tex_u,
   output logic [TEX_W-1:0]    rsp_tex_v,
   output logic [31:0]         rsp_vert_color,
   output logic [CLS_W-1:0]    rsp_walk_class,
   output logic [CORNER_W-1:0] rsp_corner,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   cfg_type      cfg_ff, cfg_in;
   reg_idx_type  reg_sel;
   logic         csr_write;
   logic         f2q_valid, f2q_ready, q2b_valid, q2b_ready;
   cell_job_type f2q_job, q2b_job;

   assign pready    = 1'b1;
   assign reg_sel   = reg_idx_type'(paddr[PADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_FIRST_ID:   cfg_in.first_id      = pwdata[15:0];
            REG_TILE_TOTAL: cfg_in.tile_total    = pwdata[12:0];
            REG_ATLAS_COLS: cfg_in.atlas_columns = pwdata[7:0];
            REG_TILE_SIZE:  cfg_in.tile_size     = pwdata;
            REG_IMG_EXTENT: cfg_in.img_extent    = pwdata;
            REG_MARGIN_GAP: cfg_in.margin_gap    = pwdata;
            REG_CELL_SIZE:  cfg_in.cell_size     = pwdata;
            REG_TINT:       cfg_in.tint          = pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         REG_FIRST_ID:   prdata = {16'd0, cfg_ff.first_id};
         REG_TILE_TOTAL: prdata = {19'd0, cfg_ff.tile_total};
         REG_ATLAS_COLS: prdata = {24'd0, cfg_ff.atlas_columns};
         REG_TILE_SIZE:  prdata = cfg_ff.tile_size;
         REG_IMG_EXTENT: prdata = cfg_ff.img_extent;
         REG_MARGIN_GAP: prdata = cfg_ff.margin_gap;
         REG_CELL_SIZE:  prdata = cfg_ff.cell_size;
         REG_TINT:       prdata = cfg_ff.tint;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_id      <= 16'd1;
         cfg_ff.tile_total    <= '0;
         cfg_ff.atlas_columns <= 8'd1;
         cfg_ff.tile_size     <= '0;
         cfg_ff.img_extent    <= 32'h0001_0001;
         cfg_ff.margin_gap    <= '0;
         cfg_ff.cell_size     <= '0;
         cfg_ff.tint          <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcqg_front #(.TILE_IDS(TILE_IDS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_tile_gid   (req_tile_gid),
      .req_attr_tile  (req_attr_tile),
      .req_attr_class (req_attr_class),
      .cfg            (cfg_ff),
      .job_valid      (f2q_valid),
      .job_ready      (f2q_ready),
      .job            (f2q_job)
   );

   tcqg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f2q_valid),
      .in_ready  (f2q_ready),
      .in_job    (f2q_job),
      .out_valid (q2b_valid),
      .out_ready (q2b_ready),
      .out_job   (q2b_job)
   );

   tcqg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q2b_valid),
      .job_ready      (q2b_ready),
      .job            (q2b_job),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_vert_color (rsp_vert_color),
      .rsp_walk_class (rsp_walk_class),
      .rsp_corner     (rsp_corner),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/tcqg_checker.sv =====
// Port-level checks of the vertex stream, bound to the top level.
module tcqg_checker import tcqg_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_mode,
   input logic [9:0]          req_cell_x,
   input logic [9:0]          req_cell_y,
   input logic [15:0]         req_tile_gid,
   input logic [11:0]         req_attr_tile,
   input logic [1:0]          req_attr_class,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [POS_W-1:0]    rsp_pos_x,
   input logic [POS_W-1:0]    rsp_pos_y,
   input logic [TEX_W-1:0]    rsp_tex_u,
   input logic [TEX_W-1:0]    rsp_tex_v,
   input logic [31:0]         rsp_vert_color,
   input logic [CLS_W-1:0]    rsp_walk_class,
   input logic [CORNER_W-1:0] rsp_corner,
   input logic                rsp_last,
   input logic                psel,
   input logic                penable,
   input logic                pwrite,
   input logic [PADDR_W-1:0]  paddr,
   input logic [DATA_W-1:0]   pwdata,
   input logic [DATA_W-1:0]   prdata,
   input logic                pready
);

   // last flags exactly the sixth vertex
   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_corner == CORNER_LAST)))
      else $error("rsp_last does not match the final corner");

   // within a cell the next vertex follows at once, one corner on
   a_corner_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && (rsp_corner == $past(rsp_corner) + CORNER_W'(1))))
      else $error("vertex stream broke inside a cell");

   // a cell that follows straight after the last vertex starts at the first corner
   a_cell_starts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (!rsp_valid || (rsp_corner == '0)))
      else $error("cell did not start at corner zero");

   // stalled vertex holds its corner, x position and v coordinate
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_corner) && $stable(rsp_pos_x) && $stable(rsp_tex_v)))
      else $error("stalled vertex changed");

endmodule

bind tile_cell_quad_generator_core tcqg_checker u_tcqg_checker (.*);
